// ===== hdl/ctrs_pkg.sv =====
// Shared types and constants for the Catmull-Rom trail smoother.
`default_nettype none
package ctrs_pkg;

  localparam int MAX_SUBDIV = 31;
  localparam logic [4:0] SUBDIV_RESET = 5'd4;
  localparam int JOBQ_DEPTH = 2;

  // Divider and square-root widths cover the largest numerators of the datapath.
  localparam int DIV_NUM_W = 52;
  localparam int DIV_DEN_W = 32;
  localparam int SQ_W = 56;
  localparam int ROOT_W = SQ_W / 2;
  localparam int ACC_W = 56;
  localparam int V_W = 28;
  localparam logic [SQ_W-1:0] DIR_EPS_SQ = SQ_W'(17);

  typedef struct packed {
    logic signed [31:0] tip_x;
    logic signed [31:0] tip_y;
    logic signed [31:0] tip_z;
    logic signed [31:0] root_x;
    logic signed [31:0] root_y;
    logic signed [31:0] root_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [30:0]        point_age;
    logic               trail_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_tip_x;
    logic signed [31:0] out_tip_y;
    logic signed [31:0] out_tip_z;
    logic signed [31:0] out_root_x;
    logic signed [31:0] out_root_y;
    logic signed [31:0] out_root_z;
    logic signed [15:0] out_dir_x;
    logic signed [15:0] out_dir_y;
    logic signed [15:0] out_dir_z;
    logic [30:0]        out_age;
    logic               last_sample;
  } out_item_t;

  typedef struct packed {
    logic [5:0][31:0] pos;
    logic [2:0][15:0] dir;
    logic [30:0]      age;
  } point_t;

  // One spline segment to be sampled: pts[0..3] are p0..p3.
  typedef struct packed {
    point_t [3:0] pts;
    logic [4:0]   steps;
    logic         final_seg;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_PREP,
    B_MAC,
    B_DIVGO,
    B_DIVW,
    B_SQ,
    B_SQCHK,
    B_SQRTW,
    B_NGO,
    B_NW,
    B_AMAC,
    B_AGO,
    B_AW,
    B_OUT
  } back_state_t;

endpackage
`default_nettype wire

// ===== hdl/ctrs_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module ctrs_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [ctrs_pkg::DIV_NUM_W-1:0]   num,
  input  wire logic [ctrs_pkg::DIV_DEN_W-1:0]   den,
  output logic                                  done,
  output logic [ctrs_pkg::DIV_NUM_W-1:0]        quo
);
  localparam int NW = ctrs_pkg::DIV_NUM_W;
  localparam int DW = ctrs_pkg::DIV_DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_sh   = {rem_r, quo_r[NW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      // The numerator shifts out the top while quotient bits shift in below.
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = DW'(rem_sh - {1'b0, den_r});
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

// ===== hdl/ctrs_isqrt.sv =====
// Integer square root, two radicand bits per cycle.
`default_nettype none
module ctrs_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [ctrs_pkg::SQ_W-1:0]     radicand,
  output logic                               done,
  output logic [ctrs_pkg::ROOT_W-1:0]        root
);
  localparam int SW = ctrs_pkg::SQ_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW-1:0] x_r, x_nxt;
  logic [SW-1:0] r_r, r_nxt;
  logic [SW-1:0] bit_r, bit_nxt;
  logic [SW-1:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    x_nxt    = x_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    trial    = r_r + bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      x_nxt    = radicand;
      r_nxt    = '0;
      bit_nxt  = SW'(1) << (SW - 2);
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_nxt = x_r - trial;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r   <= x_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = r_r[ctrs_pkg::ROOT_W-1:0];
endmodule
`default_nettype wire

// ===== hdl/ctrs_jobq.sv =====
// Short queue of segment jobs between the front and back parts.
`default_nettype none
module ctrs_jobq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ctrs_pkg::job_t wdata,
  input  wire logic           pop,
  output logic                full,
  output logic                valid,
  output ctrs_pkg::job_t      rdata
);
  localparam int D  = ctrs_pkg::JOBQ_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int NW = $clog2(D + 1);

  ctrs_pkg::job_t mem_r [D];
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [NW-1:0]  n_r, n_nxt;
  logic           do_push, do_pop;

  always_comb begin
    do_push = push && (n_r != NW'(D));
    do_pop  = pop && (n_r != '0);
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    if (do_push) wp_nxt = (wp_r == PW'(D - 1)) ? '0 : wp_r + PW'(1);
    if (do_pop) rp_nxt = (rp_r == PW'(D - 1)) ? '0 : rp_r + PW'(1);
    n_nxt = n_r + NW'(do_push) - NW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      n_r  <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      n_r  <= n_nxt;
    end
    if (do_push) mem_r[wp_r] <= wdata;
  end

  assign full  = (n_r == NW'(D));
  assign valid = (n_r != '0);
  assign rdata = mem_r[rp_r];
endmodule
`default_nettype wire

// ===== hdl/ctrs_front.sv =====
// Front part: takes control points, keeps the point window and issues segment jobs.
`default_nettype none
module ctrs_front #(
  parameter int MAX_SUBDIVISIONS = ctrs_pkg::MAX_SUBDIV
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ctrs_pkg::in_item_t in_data,
  input  wire logic               cfg_we,
  input  wire logic [4:0]         cfg_wdata,
  input  wire logic               q_full,
  output logic                    q_push,
  output ctrs_pkg::job_t          q_wdata
);
  logic [4:0]       subdiv_r;
  logic [1:0]       seen_r, seen_nxt;
  ctrs_pkg::point_t win_r [3];
  logic             pend_r, pend_nxt;
  ctrs_pkg::job_t   pend_job_r;
  ctrs_pkg::point_t np;
  ctrs_pkg::job_t   j1, j2;
  logic [4:0]       steps;
  logic             accept, has1, has2;

  always_comb begin
    if (subdiv_r == 5'd0) steps = 5'd1;
    else if (subdiv_r > 5'(MAX_SUBDIVISIONS)) steps = 5'(MAX_SUBDIVISIONS);
    else steps = subdiv_r;

    np.pos = {in_data.root_z, in_data.root_y, in_data.root_x,
              in_data.tip_z, in_data.tip_y, in_data.tip_x};
    np.dir = {in_data.dir_z, in_data.dir_y, in_data.dir_x};
    np.age = in_data.point_age;

    in_ready = !pend_r && !q_full;
    accept   = in_valid && in_ready;
    has1     = (seen_r >= 2'd2);
    has2     = in_data.trail_end && (seen_r != 2'd0);

    // Middle segment p1->p2 with the new point as p3; the start is clamped.
    j1.pts[0]    = (seen_r == 2'd3) ? win_r[0] : win_r[1];
    j1.pts[1]    = win_r[1];
    j1.pts[2]    = win_r[2];
    j1.pts[3]    = np;
    j1.steps     = steps;
    j1.final_seg = 1'b0;

    // Final segment of a trail, with the end point duplicated as p3.
    j2.pts[0]    = has1 ? win_r[1] : win_r[2];
    j2.pts[1]    = win_r[2];
    j2.pts[2]    = np;
    j2.pts[3]    = np;
    j2.steps     = steps;
    j2.final_seg = 1'b1;

    q_push   = 1'b0;
    q_wdata  = j1;
    pend_nxt = pend_r;
    if (pend_r) begin
      q_push  = !q_full;
      q_wdata = pend_job_r;
      if (!q_full) pend_nxt = 1'b0;
    end else if (accept) begin
      if (has1) begin
        q_push = 1'b1;
        if (has2) pend_nxt = 1'b1;
      end else if (has2) begin
        q_push  = 1'b1;
        q_wdata = j2;
      end
    end

    seen_nxt = seen_r;
    if (accept) begin
      if (in_data.trail_end) seen_nxt = 2'd0;
      else if (seen_r != 2'd3) seen_nxt = seen_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subdiv_r <= ctrs_pkg::SUBDIV_RESET;
      seen_r   <= 2'd0;
      pend_r   <= 1'b0;
    end else begin
      if (cfg_we) subdiv_r <= cfg_wdata;
      seen_r <= seen_nxt;
      pend_r <= pend_nxt;
    end
    if (accept) begin
      win_r[0]   <= win_r[1];
      win_r[1]   <= win_r[2];
      win_r[2]   <= np;
      pend_job_r <= j2;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ctrs_back.sv =====
// Back part: samples each segment job with multipliers, a shared divider and a root unit.
`default_nettype none
module ctrs_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire ctrs_pkg::job_t q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ctrs_pkg::out_item_t out_data
);
  localparam int NW = ctrs_pkg::DIV_NUM_W;
  localparam int DW = ctrs_pkg::DIV_DEN_W;
  localparam int AW = ctrs_pkg::ACC_W;
  localparam int VW = ctrs_pkg::V_W;
  localparam int SW = ctrs_pkg::SQ_W;
  localparam int RW = ctrs_pkg::ROOT_W;

  ctrs_pkg::back_state_t state_r, state_nxt;
  ctrs_pkg::job_t        job_r, job_nxt;
  logic [4:0]            j_r, j_nxt;
  logic [3:0]            comp_r, comp_nxt;
  logic [1:0]            k_r, k_nxt;
  logic signed [AW-1:0]  acc_r, acc_nxt;
  logic [3:0][15:0]      w_r, w_nxt;
  logic [5:0][31:0]      pos_r, pos_nxt;
  logic signed [VW-1:0]  v_r [3];
  logic signed [VW-1:0]  v_nxt [3];
  logic [SW-1:0]         sq_r, sq_nxt;
  logic [RW-1:0]         len_r, len_nxt;
  logic [2:0][15:0]      nd_r, nd_nxt;
  logic [30:0]           age_r, age_nxt;

  logic signed [36:0] p0, p1, p2, p3, coef;
  logic signed [AW-1:0] prod, nsel, nmag;
  logic signed [2*VW-1:0] vsq;
  logic [VW-1:0]      vabs;
  logic [5:0]         cnt, jn;
  logic [4:0]         s;
  logic               last;
  logic               div_start, div_done, sq_start, sq_done;
  logic [NW-1:0]      div_num, div_quo;
  logic [DW-1:0]      div_den;
  logic [RW-1:0]      root;

  function automatic logic signed [36:0] pick(ctrs_pkg::point_t p, logic [3:0] c);
    logic [1:0] d;
    d = 2'(c - 4'd6);
    if (c < 4'd6) pick = 37'($signed(p.pos[c[2:0]]));
    else pick = 37'($signed(p.dir[d]));
  endfunction

  ctrs_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  ctrs_isqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .radicand(sq_r),
    .done    (sq_done),
    .root    (root)
  );

  always_comb begin
    s    = job_r.steps;
    cnt  = {1'b0, s} + 6'(job_r.final_seg);
    jn   = {1'b0, j_r} + 6'd1;
    last = job_r.final_seg && (jn == cnt);

    p0 = pick(job_r.pts[0], comp_r);
    p1 = pick(job_r.pts[1], comp_r);
    p2 = pick(job_r.pts[2], comp_r);
    p3 = pick(job_r.pts[3], comp_r);
    case (k_r)
      2'd0:    coef = p1 <<< 1;
      2'd1:    coef = p2 - p0;
      2'd2:    coef = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
      default: coef = -p0 + ((p1 <<< 1) + p1) - ((p2 <<< 1) + p2) + p3;
    endcase
    prod = coef * $signed({1'b0, w_r[k_r]});
    vsq  = v_r[k_r] * v_r[k_r];

    // Direction components are divided in Q.22, eight bits above Q.14.
    nsel = (comp_r >= 4'd6) ? (acc_r <<< 8) : acc_r;
    nmag = nsel[AW-1] ? -nsel : nsel;
    vabs = v_r[k_r][VW-1] ? VW'(-v_r[k_r]) : VW'(v_r[k_r]);

    div_num = NW'(nmag) + NW'(w_r[0]);
    div_den = DW'({w_r[0], 1'b0});
    if (state_r == ctrs_pkg::B_NGO) begin
      div_num = NW'({vabs, 14'd0}) + NW'(len_r >> 1);
      div_den = DW'(len_r);
    end else if (state_r == ctrs_pkg::B_AGO) begin
      div_num = NW'(acc_r) + NW'(s >> 1);
      div_den = DW'(s);
    end

    state_nxt = state_r;
    job_nxt   = job_r;
    j_nxt     = j_r;
    comp_nxt  = comp_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    w_nxt     = w_r;
    pos_nxt   = pos_r;
    v_nxt     = v_r;
    sq_nxt    = sq_r;
    len_nxt   = len_r;
    nd_nxt    = nd_r;
    age_nxt   = age_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    sq_start  = 1'b0;

    unique case (state_r)
      ctrs_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          job_nxt   = q_rdata;
          j_nxt     = '0;
          state_nxt = ctrs_pkg::B_PREP;
        end
      end
      ctrs_pkg::B_PREP: begin
        // Weights of a0..a3: s^3, j*s^2, j^2*s, j^3.
        w_nxt[0]  = 16'(s * s * s);
        w_nxt[1]  = 16'(j_r * s * s);
        w_nxt[2]  = 16'(j_r * j_r * s);
        w_nxt[3]  = 16'(j_r * j_r * j_r);
        comp_nxt  = '0;
        k_nxt     = '0;
        state_nxt = ctrs_pkg::B_MAC;
      end
      ctrs_pkg::B_MAC: begin
        acc_nxt = (k_r == 2'd0) ? prod : acc_r + prod;
        k_nxt   = k_r + 2'd1;
        if (k_r == 2'd3) state_nxt = ctrs_pkg::B_DIVGO;
      end
      ctrs_pkg::B_DIVGO: begin
        div_start = 1'b1;
        state_nxt = ctrs_pkg::B_DIVW;
      end
      ctrs_pkg::B_DIVW: begin
        if (div_done) begin
          if (comp_r < 4'd6) begin
            if (!acc_r[AW-1]) begin
              pos_nxt[comp_r[2:0]] = (|div_quo[NW-1:31]) ? 32'h7FFF_FFFF : div_quo[31:0];
            end else if ((|div_quo[NW-1:32]) || (div_quo[31] && (|div_quo[30:0]))) begin
              pos_nxt[comp_r[2:0]] = 32'h8000_0000;
            end else begin
              pos_nxt[comp_r[2:0]] = -div_quo[31:0];
            end
          end else begin
            v_nxt[2'(comp_r - 4'd6)] = acc_r[AW-1] ? -$signed(div_quo[VW-1:0])
                                                  : $signed(div_quo[VW-1:0]);
          end
          k_nxt = '0;
          if (comp_r == 4'd8) begin
            sq_nxt    = '0;
            state_nxt = ctrs_pkg::B_SQ;
          end else begin
            comp_nxt  = comp_r + 4'd1;
            state_nxt = ctrs_pkg::B_MAC;
          end
        end
      end
      ctrs_pkg::B_SQ: begin
        sq_nxt = sq_r + SW'($unsigned(vsq));
        k_nxt  = k_r + 2'd1;
        if (k_r == 2'd2) state_nxt = ctrs_pkg::B_SQCHK;
      end
      ctrs_pkg::B_SQCHK: begin
        k_nxt = '0;
        if (sq_r > ctrs_pkg::DIR_EPS_SQ) begin
          sq_start  = 1'b1;
          state_nxt = ctrs_pkg::B_SQRTW;
        end else begin
          nd_nxt    = '0;
          state_nxt = ctrs_pkg::B_AMAC;
        end
      end
      ctrs_pkg::B_SQRTW: begin
        if (sq_done) begin
          len_nxt   = root;
          state_nxt = ctrs_pkg::B_NGO;
        end
      end
      ctrs_pkg::B_NGO: begin
        div_start = 1'b1;
        state_nxt = ctrs_pkg::B_NW;
      end
      ctrs_pkg::B_NW: begin
        if (div_done) begin
          nd_nxt[k_r] = v_r[k_r][VW-1] ? -div_quo[15:0] : div_quo[15:0];
          if (k_r == 2'd2) begin
            k_nxt     = '0;
            state_nxt = ctrs_pkg::B_AMAC;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ctrs_pkg::B_NGO;
          end
        end
      end
      ctrs_pkg::B_AMAC: begin
        // Age numerator: age1*(s-j) + age2*j, nonnegative.
        if (k_r == 2'd0) begin
          acc_nxt = AW'(job_r.pts[1].age * 6'({1'b0, s} - {1'b0, j_r}));
          k_nxt   = 2'd1;
        end else begin
          acc_nxt   = acc_r + AW'(job_r.pts[2].age * j_r);
          state_nxt = ctrs_pkg::B_AGO;
        end
      end
      ctrs_pkg::B_AGO: begin
        div_start = 1'b1;
        state_nxt = ctrs_pkg::B_AW;
      end
      ctrs_pkg::B_AW: begin
        if (div_done) begin
          age_nxt   = div_quo[30:0];
          state_nxt = ctrs_pkg::B_OUT;
        end
      end
      ctrs_pkg::B_OUT: begin
        if (out_ready) begin
          if (jn == cnt) begin
            state_nxt = ctrs_pkg::B_IDLE;
          end else begin
            j_nxt     = j_r + 5'd1;
            state_nxt = ctrs_pkg::B_PREP;
          end
        end
      end
      default: state_nxt = ctrs_pkg::B_IDLE;
    endcase

    out_valid            = (state_r == ctrs_pkg::B_OUT);
    out_data.out_tip_x   = pos_r[0];
    out_data.out_tip_y   = pos_r[1];
    out_data.out_tip_z   = pos_r[2];
    out_data.out_root_x  = pos_r[3];
    out_data.out_root_y  = pos_r[4];
    out_data.out_root_z  = pos_r[5];
    out_data.out_dir_x   = nd_r[0];
    out_data.out_dir_y   = nd_r[1];
    out_data.out_dir_z   = nd_r[2];
    out_data.out_age     = age_r;
    out_data.last_sample = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctrs_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    job_r  <= job_nxt;
    j_r    <= j_nxt;
    comp_r <= comp_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    w_r    <= w_nxt;
    pos_r  <= pos_nxt;
    v_r    <= v_nxt;
    sq_r   <= sq_nxt;
    len_r  <= len_nxt;
    nd_r   <= nd_nxt;
    age_r  <= age_nxt;
  end
endmodule
`default_nettype wire

// ===== hdl/catmull_rom_trail_smoother.sv =====
// Top level of the Catmull-Rom trail smoother.
// Control points enter through a front part that keeps the last three points
// and queues one job per spline segment (up to two jobs when a point ends a
// trail); a back part then produces each sample sequentially. A sample needs
// thirteen quotients on one shared bit-serial divider (six positions, three
// directions, three renormalizations, age) and a square root, or ten
// quotients and no square root when the direction is too short to be
// renormalized. An item costs about steps samples for each segment it closes,
// plus one more sample on the last point of a trail. The front keeps taking
// points while the two-entry job queue has room and no second job is waiting.
`default_nettype none
module catmull_rom_trail_smoother #(
  parameter int MAX_SUBDIVISIONS = ctrs_pkg::MAX_SUBDIV
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ctrs_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ctrs_pkg::out_item_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic [4:0]         cfg_wdata
);
  logic           q_full, q_push, q_valid, q_pop;
  ctrs_pkg::job_t q_wdata, q_rdata;

  ctrs_front #(
    .MAX_SUBDIVISIONS(MAX_SUBDIVISIONS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  ctrs_jobq u_jobq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .full (q_full),
    .valid(q_valid),
    .rdata(q_rdata)
  );

  ctrs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );
endmodule
`default_nettype wire
